// ===== hdl/phdlc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package phdlc_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7e;
  localparam logic [7:0]  ESC_BYTE  = 8'h7d;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [7:0]  ADDR_BYTE = 8'hff;
  localparam logic [7:0]  CTRL_BYTE = 8'h03;
  localparam logic [15:0] FCS_INIT  = 16'hffff;
  localparam logic [15:0] FCS_POLY  = 16'h8408;

  localparam int unsigned PADDR_W  = 3;
  localparam logic        REG_ACCM = 1'b0;
  localparam logic [31:0] ACCM_RST = 32'hffff_ffff;

  typedef enum logic [2:0] {
    TOK_OPEN,
    TOK_ADDR,
    TOK_CTRL,
    TOK_DATA,
    TOK_FCS_LO,
    TOK_FCS_HI,
    TOK_CLOSE
  } tok_e;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [15:0] trailer;
  } item_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       frame_end;
    logic       run_last;
  } emit_t;

  function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] f;
    f = fcs ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (f[0]) begin
        f = (f >> 1) ^ FCS_POLY;
      end else begin
        f = f >> 1;
      end
    end
    return f;
  endfunction

  localparam logic [15:0] FCS_HDR = fcs_update(fcs_update(FCS_INIT, ADDR_BYTE), CTRL_BYTE);

endpackage

`default_nettype wire

// ===== hdl/ppp_async_hdlc_framer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake                      payload
// in       sink       in_valid_i / in_stall_o        in_data_byte_i, in_last_byte_i
// out      source     out_valid_o / out_stall_i      out_line_byte_o, out_frame_end_o,
//                                                    out_run_last_o
// cfg      sink       psel/penable/pwrite, pready=1  paddr, pwdata, prdata
//
// One line byte leaves per cycle through the output register unless the output stalls.
// An item causes 1 to 11 line bytes (flag, header, escapes, FCS, closing flag), and a
// mid-frame byte that needs no escape causes a single one; the next item is taken in the
// cycle its predecessor hands its final byte to the output register.
// Reset sets the control map to all ones, closes any frame and sets the FCS to 0xffff.
// A stall on the output holds the output register and, while an item is held, the
// input.

module ppp_async_hdlc_framer_unit (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire [7:0]                      in_data_byte_i,
  input  wire                            in_last_byte_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic [7:0]                     out_line_byte_o,
  output logic                           out_frame_end_o,
  output logic                           out_run_last_o,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [phdlc_pkg::PADDR_W-1:0]   paddr,
  input  wire [31:0]                     pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [31:0]      accm_q;
  logic [15:0]      fcs_q, fcs_d;
  logic             in_frame_q, in_frame_d;
  logic             item_vld_q, item_vld_d;
  phdlc_pkg::item_t item_q, item_d;
  logic             out_vld_q;
  phdlc_pkg::emit_t out_q;
  phdlc_pkg::emit_t em;
  logic             out_take;
  logic             adv;
  logic             item_done;
  logic             in_acc;
  logic [15:0]      fcs_base;
  logic [15:0]      fcs_new;

  assign pready = 1'b1;
  assign prdata = (paddr[phdlc_pkg::PADDR_W-1] == phdlc_pkg::REG_ACCM) ? accm_q : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accm_q <= phdlc_pkg::ACCM_RST;
    end else if (psel && penable && pwrite &&
                 (paddr[phdlc_pkg::PADDR_W-1] == phdlc_pkg::REG_ACCM)) begin
      accm_q <= pwdata;
    end
  end

  assign out_take   = !out_vld_q || !out_stall_i;
  assign adv        = item_vld_q && out_take;
  assign item_done  = adv && em.run_last;
  assign in_stall_o = item_vld_q && !item_done;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    fcs_base   = in_frame_q ? fcs_q : phdlc_pkg::FCS_HDR;
    fcs_new    = phdlc_pkg::fcs_update(fcs_base, in_data_byte_i);
    fcs_d      = fcs_q;
    in_frame_d = in_frame_q;
    item_vld_d = item_vld_q;
    item_d     = item_q;
    if (in_acc) begin
      item_vld_d     = 1'b1;
      item_d.data    = in_data_byte_i;
      item_d.last    = in_last_byte_i;
      item_d.trailer = ~fcs_new;
      if (in_last_byte_i) begin
        fcs_d      = phdlc_pkg::FCS_INIT;
        in_frame_d = 1'b0;
      end else begin
        fcs_d      = fcs_new;
        in_frame_d = 1'b1;
      end
    end else if (item_done) begin
      item_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcs_q      <= phdlc_pkg::FCS_INIT;
      in_frame_q <= 1'b0;
      item_vld_q <= 1'b0;
    end else begin
      fcs_q      <= fcs_d;
      in_frame_q <= in_frame_d;
      item_vld_q <= item_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  phdlc_byte_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_q),
    .accm_i      (accm_q),
    .load_i      (in_acc),
    .load_open_i (!in_frame_q),
    .adv_i       (adv),
    .emit_o      (em)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= em;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_line_byte_o = out_q.line_byte;
  assign out_frame_end_o = out_q.frame_end;
  assign out_run_last_o  = out_q.run_last;

  a_close_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_frame_end_o |-> out_run_last_o)
    else $error("closing flag not marked as last of its transaction");

  a_esc_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_line_byte_o == phdlc_pkg::ESC_BYTE) |-> !out_run_last_o)
    else $error("escape prefix ends a transaction");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_last_byte_i |=> !in_frame_q && (fcs_q == phdlc_pkg::FCS_INIT))
    else $error("frame state not cleared after last byte");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && item_vld_q |-> item_done)
    else $error("held item overwritten before done");

endmodule

`default_nettype wire

// ===== hdl/phdlc_byte_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module phdlc_byte_emit (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire phdlc_pkg::item_t item_i,
  input  wire [31:0]            accm_i,
  input  wire                   load_i,
  input  wire                   load_open_i,
  input  wire                   adv_i,
  output phdlc_pkg::emit_t      emit_o
);

  phdlc_pkg::tok_e tok_q, tok_d, tok_nxt;
  logic            half_q, half_d;
  logic [7:0]      raw_byte;
  logic            can_esc;
  logic            esc;
  logic            tok_final;
  logic            tok_fin;

  always_comb begin
    raw_byte  = phdlc_pkg::FLAG_BYTE;
    can_esc   = 1'b1;
    tok_final = 1'b0;
    tok_nxt   = tok_q;
    case (tok_q)
      phdlc_pkg::TOK_OPEN: begin
        can_esc = 1'b0;
        tok_nxt = phdlc_pkg::TOK_ADDR;
      end
      phdlc_pkg::TOK_ADDR: begin
        raw_byte = phdlc_pkg::ADDR_BYTE;
        tok_nxt  = phdlc_pkg::TOK_CTRL;
      end
      phdlc_pkg::TOK_CTRL: begin
        raw_byte = phdlc_pkg::CTRL_BYTE;
        tok_nxt  = phdlc_pkg::TOK_DATA;
      end
      phdlc_pkg::TOK_DATA: begin
        raw_byte  = item_i.data;
        tok_final = !item_i.last;
        tok_nxt   = phdlc_pkg::TOK_FCS_LO;
      end
      phdlc_pkg::TOK_FCS_LO: begin
        raw_byte = item_i.trailer[7:0];
        tok_nxt  = phdlc_pkg::TOK_FCS_HI;
      end
      phdlc_pkg::TOK_FCS_HI: begin
        raw_byte = item_i.trailer[15:8];
        tok_nxt  = phdlc_pkg::TOK_CLOSE;
      end
      phdlc_pkg::TOK_CLOSE: begin
        can_esc   = 1'b0;
        tok_final = 1'b1;
        tok_nxt   = phdlc_pkg::TOK_CLOSE;
      end
      default: begin
        can_esc = 1'b0;
        tok_nxt = phdlc_pkg::TOK_OPEN;
      end
    endcase
    esc = can_esc && ((raw_byte == phdlc_pkg::ESC_BYTE) || (raw_byte == phdlc_pkg::FLAG_BYTE) ||
                      ((raw_byte[7:5] == 3'b000) && accm_i[raw_byte[4:0]]));
    tok_fin = !esc || half_q;
  end

  always_comb begin
    tok_d  = tok_q;
    half_d = half_q;
    if (load_i) begin
      tok_d  = load_open_i ? phdlc_pkg::TOK_OPEN : phdlc_pkg::TOK_DATA;
      half_d = 1'b0;
    end else if (adv_i) begin
      if (tok_fin) begin
        half_d = 1'b0;
        tok_d  = tok_nxt;
      end else begin
        half_d = 1'b1;
      end
    end
  end

  always_comb begin
    emit_o.line_byte = raw_byte;
    if (esc && !half_q) begin
      emit_o.line_byte = phdlc_pkg::ESC_BYTE;
    end else if (esc) begin
      emit_o.line_byte = raw_byte ^ phdlc_pkg::ESC_XOR;
    end
    emit_o.frame_end = (tok_q == phdlc_pkg::TOK_CLOSE);
    emit_o.run_last  = tok_fin && tok_final;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= phdlc_pkg::TOK_OPEN;
      half_q <= 1'b0;
    end else begin
      tok_q  <= tok_d;
      half_q <= half_d;
    end
  end

endmodule

`default_nettype wire
